// File: sv/sensor_dump_poller_defines.svh
// ---------------------------------------------------------------------------
// sensor_dump_poller_defines
// assertion macros shared by the sensor dump poller
// ---------------------------------------------------------------------------
`ifndef SENSOR_DUMP_POLLER_DEFINES_SVH
`define SENSOR_DUMP_POLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor dump poller: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor dump poller: next-cycle check failed");

`endif

// File: sv/sdp_pkg.sv
// ---------------------------------------------------------------------------
// sdp_pkg
// shared types, constants and helpers of the sensor dump poller
// ---------------------------------------------------------------------------
package sdp_pkg;

   // fixed field widths
   localparam int BYTE_W   = 8;
   localparam int MOD_W    = 3;
   localparam int SENSOR_W = 5;
   localparam int SCAN_W   = 16;
   localparam int CNT_W    = 4;
   localparam int CSR_IDX_W = 2;

   // parameter defaults
   localparam int MODULE_COUNT_DEF = 5;
   localparam int RECENT_DEPTH_DEF = 15;

   // register reset values
   localparam logic [BYTE_W-1:0] DUMP_CMD_RST   = 8'd133;
   localparam logic [BYTE_W-1:0] FOLLOW_CMD_RST = 8'd192;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DUMP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLLOW = 2'd1;

   // result kinds
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_CMD    = 2'd1,
      KIND_SENSOR = 2'd2
   } kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic     load_out;
      kind_type out_kind;
      logic     out_follow;
      logic     out_taken;
      logic     out_last;
      logic     cap_first;
      logic     cap_pair;
      logic     scan_step;
      logic     list_write;
      logic     mod_step;
   } sdp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic can_load;
      logic bit_set;
      logic hit;
      logic scan_done;
      logic last_module;
   } sdp_stat_type;

   // row pointer width for a list depth
   function automatic int sdp_row_w(input int depth);
      int w;
      w = (depth > 1) ? $clog2(depth) : 1;
      return w;
   endfunction

endpackage

// File: sv/sdp_ctrl.sv
// ---------------------------------------------------------------------------
// sdp_ctrl
// poll sequencer: link phase tracking and bit scan sequencing
// ---------------------------------------------------------------------------
module sdp_ctrl
   import sdp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_rx_valid,
   output logic         req_stall,
   input  sdp_stat_type stat,
   output sdp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_ACCEPT = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FOLLOW = 3'b100
   } ctrl_state_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SENT  = 3'b010,
      PH_BYTE1 = 3'b100
   } phase_type;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.out_kind = KIND_NONE;
      unique case (state_ff)
         ST_ACCEPT: begin
            req_stall = !stat.can_load;
            if (req_valid && stat.can_load) begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     cmd.load_out = 1'b1;
                     cmd.out_kind = KIND_CMD;
                     cmd.out_last = 1'b1;
                     phase_in     = PH_SENT;
                  end
                  PH_SENT: begin
                     cmd.load_out = 1'b1;
                     cmd.out_last = 1'b1;
                     if (req_rx_valid) begin
                        cmd.cap_first = 1'b1;
                        cmd.out_taken = 1'b1;
                        phase_in      = PH_BYTE1;
                     end
                  end
                  PH_BYTE1: begin
                     if (req_rx_valid) begin
                        cmd.cap_pair = 1'b1;
                        state_in     = ST_SCAN;
                     end else begin
                        cmd.load_out = 1'b1;
                        cmd.out_last = 1'b1;
                     end
                  end
                  default: begin
                     cmd.load_out = 1'b1;
                     cmd.out_last = 1'b1;
                     phase_in     = PH_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one sensor bit per cycle, report waits for room in the output register
            if (stat.bit_set && !stat.hit) begin
               if (stat.can_load) begin
                  cmd.load_out   = 1'b1;
                  cmd.out_kind   = KIND_SENSOR;
                  cmd.out_taken  = 1'b1;
                  cmd.list_write = 1'b1;
                  cmd.scan_step  = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
            if (cmd.scan_step && stat.scan_done) begin
               state_in = ST_FOLLOW;
            end
         end
         ST_FOLLOW: begin
            if (stat.can_load) begin
               cmd.load_out   = 1'b1;
               cmd.out_kind   = KIND_CMD;
               cmd.out_follow = 1'b1;
               cmd.out_taken  = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.mod_step   = 1'b1;
               phase_in       = stat.last_module ? PH_IDLE : PH_SENT;
               state_in       = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: sv/sdp_dp.sv
// ---------------------------------------------------------------------------
// sdp_dp
// datapath: command registers, byte capture, recent list and result register
// ---------------------------------------------------------------------------
module sdp_dp
   import sdp_pkg::*;
#(
   parameter int MODULE_COUNT = MODULE_COUNT_DEF,
   parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [CSR_IDX_W-1:0]             csr_index,
   input  logic [BYTE_W-1:0]                csr_wdata,
   input  logic [BYTE_W-1:0]                req_rx_byte,
   input  sdp_cmd_type                      cmd,
   output sdp_stat_type                     stat,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [BYTE_W-1:0]                rsp_tx_byte,
   output logic [MOD_W-1:0]                 rsp_module_id,
   output logic [SENSOR_W-1:0]              rsp_sensor_number,
   output logic [sdp_row_w(RECENT_DEPTH)-1:0] rsp_row,
   output logic                             rsp_byte_taken,
   output logic                             rsp_last
);

   localparam int ROW_W = sdp_row_w(RECENT_DEPTH);

   logic [BYTE_W-1:0]   dump_ff, follow_ff;
   logic [BYTE_W-1:0]   first_ff;
   logic [SCAN_W-1:0]   scan_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [MOD_W-1:0]    module_ff;
   logic [ROW_W-1:0]    next_row_ff, next_row_in;
   logic [RECENT_DEPTH-1:0] entry_valid_ff;
   logic [MOD_W-1:0]    entry_mod_ff [RECENT_DEPTH];
   logic [SENSOR_W-1:0] entry_num_ff [RECENT_DEPTH];
   logic [RECENT_DEPTH-1:0] hit_vec;
   logic [SENSOR_W-1:0] cur_num;

   logic                out_valid_ff;
   kind_type            kind_ff;
   logic [BYTE_W-1:0]   tx_ff;
   logic [MOD_W-1:0]    mod_out_ff;
   logic [SENSOR_W-1:0] num_out_ff;
   logic [ROW_W-1:0]    row_out_ff;
   logic                taken_ff, last_ff;

   // sensor number of the bit under scan, msb first
   assign cur_num = SENSOR_W'(cnt_ff) + SENSOR_W'(1);

   // compare the current sensor against every list entry
   always_comb begin
      for (int i = 0; i < RECENT_DEPTH; i++) begin
         hit_vec[i] = entry_valid_ff[i] && (entry_mod_ff[i] == module_ff) &&
                      (entry_num_ff[i] == cur_num);
      end
   end

   // row pointer wraps at the list depth
   assign next_row_in = (next_row_ff == ROW_W'(RECENT_DEPTH - 1)) ? '0 :
                        next_row_ff + ROW_W'(1);

   // status to the controller
   assign stat.can_load    = !out_valid_ff || !rsp_stall;
   assign stat.bit_set     = scan_ff[SCAN_W-1];
   assign stat.hit         = |hit_vec;
   assign stat.scan_done   = (cnt_ff == CNT_W'(SCAN_W - 1));
   assign stat.last_module = (module_ff >= MOD_W'(MODULE_COUNT - 1));

   // command registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dump_ff   <= DUMP_CMD_RST;
         follow_ff <= FOLLOW_CMD_RST;
      end else if (csr_write_en) begin
         if (csr_index == CSR_DUMP) begin
            dump_ff <= csr_wdata;
         end
         if (csr_index == CSR_FOLLOW) begin
            follow_ff <= csr_wdata;
         end
      end
   end

   // module index, row pointer, list valid bits and first captured byte
   always_ff @(posedge clock) begin
      if (reset) begin
         module_ff      <= '0;
         next_row_ff    <= '0;
         entry_valid_ff <= '0;
         first_ff       <= '0;
      end else begin
         if (cmd.cap_first) begin
            first_ff <= req_rx_byte;
         end
         if (cmd.mod_step) begin
            module_ff <= stat.last_module ? '0 : module_ff + MOD_W'(1);
         end
         if (cmd.list_write) begin
            entry_valid_ff[next_row_ff] <= 1'b1;
            next_row_ff                 <= next_row_in;
         end
      end
   end

   // list payload and scan shifter
   always_ff @(posedge clock) begin
      if (cmd.list_write) begin
         entry_mod_ff[next_row_ff] <= module_ff;
         entry_num_ff[next_row_ff] <= cur_num;
      end
      if (cmd.cap_pair) begin
         scan_ff <= {first_ff, req_rx_byte};
         cnt_ff  <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff << 1;
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         kind_ff    <= cmd.out_kind;
         tx_ff      <= '0;
         mod_out_ff <= '0;
         num_out_ff <= '0;
         row_out_ff <= '0;
         taken_ff   <= cmd.out_taken;
         last_ff    <= cmd.out_last;
         if (cmd.out_kind == KIND_CMD) begin
            tx_ff <= cmd.out_follow ? follow_ff : dump_ff;
         end
         if (cmd.out_kind == KIND_SENSOR) begin
            mod_out_ff <= module_ff;
            num_out_ff <= cur_num;
            row_out_ff <= next_row_ff;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_tx_byte       = tx_ff;
   assign rsp_module_id     = mod_out_ff;
   assign rsp_sensor_number = num_out_ff;
   assign rsp_row           = row_out_ff;
   assign rsp_byte_taken    = taken_ff;
   assign rsp_last          = last_ff;

endmodule

// File: sv/sensor_dump_poller.sv
// ---------------------------------------------------------------------------
// sensor_dump_poller: polls a sensor dump over a byte link, reports new sensors
// a plain poll sends the dump command; a second report byte starts the 16-bit scan, then the follow command
// the bit scan against the 15-entry recent list, one bit per cycle while no report waits, sets the rate
// synchronous reset restores command bytes 133/192, idle phase, empty list
// ---------------------------------------------------------------------------
`include "sensor_dump_poller_defines.svh"

module sensor_dump_poller
   import sdp_pkg::*;
#(
   parameter int MODULE_COUNT = MODULE_COUNT_DEF,
   parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [CSR_IDX_W-1:0]             csr_index,
   input  logic [BYTE_W-1:0]                csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_rx_valid,
   input  logic [BYTE_W-1:0]                req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [BYTE_W-1:0]                rsp_tx_byte,
   output logic [MOD_W-1:0]                 rsp_module_id,
   output logic [SENSOR_W-1:0]              rsp_sensor_number,
   output logic [sdp_row_w(RECENT_DEPTH)-1:0] rsp_row,
   output logic                             rsp_byte_taken,
   output logic                             rsp_last
);

   sdp_cmd_type  cmd;
   sdp_stat_type stat;

   // poll sequencer
   sdp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_rx_valid (req_rx_valid),
      .req_stall    (req_stall),
      .stat         (stat),
      .cmd          (cmd)
   );

   // datapath
   sdp_dp #(
      .MODULE_COUNT (MODULE_COUNT),
      .RECENT_DEPTH (RECENT_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_module_id     (rsp_module_id),
      .rsp_sensor_number (rsp_sensor_number),
      .rsp_row           (rsp_row),
      .rsp_byte_taken    (rsp_byte_taken),
      .rsp_last          (rsp_last)
   );

   // sensor reports are never last, always consume the byte, sit in a real row
   `SDP_ASSERT_IMPLIES(a_sensor_fields, clock, reset, rsp_valid && (rsp_kind == KIND_SENSOR), !rsp_last && rsp_byte_taken && (rsp_sensor_number != '0) && (int'(rsp_row) < RECENT_DEPTH))
   // a no-action result always closes its request
   `SDP_ASSERT_IMPLIES(a_none_last, clock, reset, rsp_valid && (rsp_kind == KIND_NONE), rsp_last)
   // while a request still has results pending no new request is taken
   `SDP_ASSERT_IMPLIES(a_busy_stall, clock, reset, rsp_valid && !rsp_last, req_stall)

endmodule
